// ===== design/lcf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcf_pkg
// shared constants and register indexes of the cycle finder
// ----------------------------------------------------------------------------
package lcf_pkg;
  localparam int WordBitsDefault = 32;
  localparam int FieldBits = 32;
  localparam int CfgIdxBits = 2;
  localparam logic [CfgIdxBits-1:0] RegMultiplier = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegIncrement  = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegModulus    = 2'd2;
endpackage

// ===== design/lcf_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcf_seed_if / lcf_result_if
// valid/ready channels for seed words and result words
// ----------------------------------------------------------------------------
interface lcf_seed_if;
  logic valid;
  logic ready;
  logic [lcf_pkg::FieldBits-1:0] start_value;
  modport source (output valid, output start_value, input ready);
  modport sink (input valid, input start_value, output ready);
endinterface

interface lcf_result_if;
  logic valid;
  logic ready;
  logic [lcf_pkg::FieldBits-1:0] tail_length;
  logic [lcf_pkg::FieldBits-1:0] cycle_length;
  logic error;
  modport source (output valid, output tail_length, output cycle_length, output error,
                  input ready);
  modport sink (input valid, input tail_length, input cycle_length, input error,
                output ready);
endinterface

// ===== design/lcf_modstep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcf_modstep
// shared generator step (a*x + c) mod m, one restoring quotient bit a cycle
// ----------------------------------------------------------------------------
module lcf_modstep #(
  parameter int WORD_BITS = lcf_pkg::WordBitsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] x,
  input  logic [WORD_BITS-1:0] a,
  input  logic [WORD_BITS-1:0] c,
  input  logic [WORD_BITS-1:0] m,
  output logic                 done,
  output logic [WORD_BITS-1:0] r
);
  localparam int DW = 2 * WORD_BITS + 1;
  localparam int CB = $clog2(DW + 2);
  localparam logic [CB-1:0] LastBit = CB'(DW - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  logic [1:0] state;
  logic [CB-1:0] cnt;
  logic [2*WORD_BITS-1:0] prod;
  logic [DW-1:0] dividend;
  logic [WORD_BITS:0] rem;
  logic [WORD_BITS+1:0] trial;

  // shift in next dividend bit, subtract when it fits
  always_comb begin
    trial = {rem, dividend[DW-1]} - {1'b0, 1'b0, m};
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            prod <= a * x;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          dividend <= {1'b0, prod} + {{(WORD_BITS + 1){1'b0}}, c};
          rem <= '0;
          cnt <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (!trial[WORD_BITS+1]) rem <= trial[WORD_BITS:0];
          else rem <= {rem[WORD_BITS-1:0], dividend[DW-1]};
          dividend <= {dividend[DW-2:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (cnt == LastBit) begin
            done <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign r = rem[WORD_BITS-1:0];
endmodule

// ===== design/lcg_cycle_finder.sv =====
`timescale 1ns / 1ps
// work: 3*k + 2*mu + lambda generator steps, k the first multiple of lambda not below
//   mu (at least one), run one at a time on the single shared modulo-step unit, plus
//   mu+1 entry compares; a zero modulus skips the steps and answers with the error flag
// throughput: one seed word at a time, taken only while the sequencer is idle
// reset: synchronous, active high; registers return to multiplier, increment
//   and modulus of one, the sequencer goes idle and no result word is pending
// ----------------------------------------------------------------------------
// lcg_cycle_finder
// tail and cycle length of a congruential sequence by tortoise and hare
// ----------------------------------------------------------------------------
module lcg_cycle_finder #(
  parameter int WORD_BITS = lcf_pkg::WordBitsDefault
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lcf_pkg::CfgIdxBits-1:0]  cfg_index,
  input  logic [lcf_pkg::FieldBits-1:0]   cfg_data,
  lcf_seed_if.sink                        seed,
  lcf_result_if.source                    result
);
  localparam int FB = lcf_pkg::FieldBits;

  // sequencer codes
  localparam logic [3:0] P_IDLE  = 4'd0;
  localparam logic [3:0] P_MEET_T = 4'd1; // tortoise one step
  localparam logic [3:0] P_MEET_H1 = 4'd2; // hare first step
  localparam logic [3:0] P_MEET_H2 = 4'd3; // hare second step, then compare
  localparam logic [3:0] P_ENTRY_CMP = 4'd4;
  localparam logic [3:0] P_ENTRY_T = 4'd5;
  localparam logic [3:0] P_ENTRY_H = 4'd6;
  localparam logic [3:0] P_LOOP = 4'd7;
  localparam logic [3:0] P_OUT = 4'd8;

  logic [WORD_BITS-1:0] multiplier, increment, modulus;
  logic [WORD_BITS-1:0] x0, tortoise, hare;
  logic [FB-1:0] mu, lam;
  logic [3:0] phase;
  logic busy; // step unit running
  logic step_start, step_done;
  logic [WORD_BITS-1:0] step_x, step_r;

  // configuration writes, low word bits only
  always_ff @(posedge clk) begin
    if (rst) begin
      multiplier <= WORD_BITS'(1);
      increment  <= WORD_BITS'(1);
      modulus    <= WORD_BITS'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        lcf_pkg::RegMultiplier: multiplier <= cfg_data[WORD_BITS-1:0];
        lcf_pkg::RegIncrement:  increment  <= cfg_data[WORD_BITS-1:0];
        lcf_pkg::RegModulus:    modulus    <= cfg_data[WORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // operand of the shared step: tortoise in tortoise phases, hare otherwise
  assign step_x = (phase == P_MEET_T || phase == P_ENTRY_T) ? tortoise : hare;
  assign step_start = !busy && (phase == P_MEET_T || phase == P_MEET_H1 ||
                      phase == P_MEET_H2 || phase == P_ENTRY_T ||
                      phase == P_ENTRY_H || phase == P_LOOP);

  lcf_modstep #(.WORD_BITS(WORD_BITS)) u_step (
    .clk(clk), .rst(rst), .start(step_start), .x(step_x),
    .a(multiplier), .c(increment), .m(modulus), .done(step_done), .r(step_r)
  );

  assign seed.ready = (phase == P_IDLE);
  assign result.valid = (phase == P_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      busy <= 1'b0;
    end else begin
      if (step_start) busy <= 1'b1;
      if (step_done) busy <= 1'b0;
      case (phase)
        P_IDLE: begin
          if (seed.valid) begin
            x0 <= seed.start_value[WORD_BITS-1:0];
            tortoise <= seed.start_value[WORD_BITS-1:0];
            hare <= seed.start_value[WORD_BITS-1:0];
            mu <= '0;
            lam <= '0;
            if (modulus == '0) begin
              result.error <= 1'b1;
              phase <= P_OUT;
            end else begin
              result.error <= 1'b0;
              phase <= P_MEET_T;
            end
          end
        end
        P_MEET_T: if (step_done) begin
          tortoise <= step_r;
          phase <= P_MEET_H1;
        end
        P_MEET_H1: if (step_done) begin
          hare <= step_r;
          phase <= P_MEET_H2;
        end
        P_MEET_H2: if (step_done) begin
          hare <= step_r;
          if (step_r == tortoise) begin
            tortoise <= x0;
            phase <= P_ENTRY_CMP;
          end else phase <= P_MEET_T;
        end
        P_ENTRY_CMP: begin
          if (tortoise == hare) phase <= P_LOOP;
          else phase <= P_ENTRY_T;
        end
        P_ENTRY_T: if (step_done) begin
          tortoise <= step_r;
          phase <= P_ENTRY_H;
        end
        P_ENTRY_H: if (step_done) begin
          hare <= step_r;
          mu <= mu + 1'b1;
          phase <= P_ENTRY_CMP;
        end
        P_LOOP: if (step_done) begin
          hare <= step_r;
          lam <= lam + 1'b1;
          if (step_r == tortoise) phase <= P_OUT;
        end
        P_OUT: if (result.ready) phase <= P_IDLE;
        default: phase <= P_IDLE;
      endcase
    end
  end

  assign result.tail_length = mu;
  assign result.cycle_length = lam;
endmodule

// ===== verif/lcg_cycle_finder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg_cycle_finder_tb
// self-checking bench: walks a table of seeds under several generator
// settings, then random seeds and settings, and checks every result word
// against its typed-in expectation or its own tortoise-and-hare predictor
// ----------------------------------------------------------------------------
module lcg_cycle_finder_tb;

  localparam int RandomSeeds = 115;
  localparam int QuietTail = 20;      // last seeds go without idling
  localparam int WatchdogLimit = 500000;

  typedef struct packed {
    logic [31:0] tail;
    logic [31:0] cycle;
    logic        err;
  } lengths_t;

  typedef struct {
    logic [31:0] mult;
    logic [31:0] inc;
    logic [31:0] modv;
    logic [31:0] start;
    bit          known;
    lengths_t    want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [lcf_pkg::CfgIdxBits-1:0] cfg_index = lcf_pkg::RegMultiplier;
  logic [lcf_pkg::FieldBits-1:0] cfg_data = '0;

  lcf_seed_if seed_ch ();
  lcf_result_if result_ch ();

  lcg_cycle_finder i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .seed      (seed_ch),
    .result    (result_ch)
  );

  always #10 clk = ~clk;

  // generator settings as the block should hold them
  logic [31:0] mult_q = 32'd1;
  logic [31:0] inc_q = 32'd1;
  logic [31:0] mod_q = 32'd1;

  lengths_t pending_lengths[$];
  bit failed = 1'b0;
  bit quiet = 1'b0;
  int stall_left = 0;
  int idle_cycles = 0;

  // one generator step, product at double width so nothing overflows
  function automatic logic [31:0] gen_next(logic [31:0] x);
    return 32'((64'(mult_q) * 64'(x) + 64'(inc_q)) % 64'(mod_q));
  endfunction

  // floyd: meet in the cycle, find its entry, then measure it
  function automatic lengths_t floyd_lengths(logic [31:0] x0);
    logic [31:0] t;
    logic [31:0] h;
    lengths_t r;
    r = '0;
    if (mod_q == 32'd0) begin
      r.err = 1'b1;
      return r;
    end
    t = gen_next(x0);
    h = gen_next(gen_next(x0));
    while (t != h) begin
      t = gen_next(t);
      h = gen_next(gen_next(h));
    end
    t = x0;
    while (t != h) begin
      t = gen_next(t);
      h = gen_next(h);
      r.tail++;
    end
    do begin
      h = gen_next(h);
      r.cycle++;
    end while (h != t);
    return r;
  endfunction

  // register writes only once every outstanding result word is back
  task automatic set_generator(logic [31:0] a, logic [31:0] c, logic [31:0] m);
    wait (pending_lengths.size() == 0);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= lcf_pkg::RegMultiplier;
    cfg_data <= a;
    @(posedge clk);
    cfg_index <= lcf_pkg::RegIncrement;
    cfg_data <= c;
    @(posedge clk);
    cfg_index <= lcf_pkg::RegModulus;
    cfg_data <= m;
    @(posedge clk);
    // index past the register list must leave everything alone
    cfg_index <= 2'd3;
    cfg_data <= $urandom();
    @(posedge clk);
    cfg_we <= 1'b0;
    mult_q = a;
    inc_q = c;
    mod_q = m;
  endtask

  // offer one seed word, hold it until taken; valid stays high afterwards
  task automatic send_seed(logic [31:0] x0, bit known, lengths_t want);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      seed_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    seed_ch.valid <= 1'b1;
    seed_ch.start_value <= x0;
    @(posedge clk);
    while (!seed_ch.ready) @(posedge clk);
    pending_lengths.push_back(known ? want : floyd_lengths(x0));
  endtask

  task automatic drop_valid();
    seed_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // result side: random stall bursts, checking and the watchdog
  always @(posedge clk) begin
    lengths_t exp_w;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        if (pending_lengths.size() == 0) begin
          $error("result word with nothing expected");
          failed = 1'b1;
        end else begin
          exp_w = pending_lengths.pop_front();
          if (result_ch.tail_length !== exp_w.tail) begin
            $error("tail_length exp %0d got %0d", exp_w.tail, result_ch.tail_length);
            failed = 1'b1;
          end
          if (result_ch.cycle_length !== exp_w.cycle) begin
            $error("cycle_length exp %0d got %0d", exp_w.cycle, result_ch.cycle_length);
            failed = 1'b1;
          end
          if (result_ch.error !== exp_w.err) begin
            $error("error exp %0d got %0d", exp_w.err, result_ch.error);
            failed = 1'b1;
          end
        end
      end
      if ((result_ch.valid && result_ch.ready) || (seed_ch.valid && seed_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
    // stall bursts, none in the quiet tail
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      result_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 3);
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // directed table: expectation typed in where it is obvious
  row_t directed[] = '{
    // reset settings: everything folds onto zero
    '{32'd1, 32'd1, 32'd1, 32'h0000_0000, 1'b1, '{32'd0, 32'd1, 1'b0}},
    '{32'd1, 32'd1, 32'd1, 32'hFFFF_FFFF, 1'b1, '{32'd1, 32'd1, 1'b0}},
    // identity step on the widest modulus, seed equal to it and below it
    '{32'd1, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'd1, 32'd1, 1'b0}},
    '{32'd1, 32'd0, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'd0, 32'd1, 1'b0}},
    // zero modulus flags an error
    '{32'd5, 32'd3, 32'd0, 32'd123, 1'b1, '{32'd0, 32'd0, 1'b1}},
    '{32'd5, 32'd3, 32'd0, 32'hFFFF_FFFF, 1'b1, '{32'd0, 32'd0, 1'b1}},
    // zero multiplier with full increment: one step to zero, stays there
    '{32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd5, 1'b1, '{32'd1, 32'd1, 1'b0}},
    // operands far above the modulus, then seeds below and at a modulus of 16
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd7, 32'hFFFF_FFFF, 1'b0, '0},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd7, 32'd3, 1'b0, '0},
    '{32'd3, 32'd1, 32'd16, 32'd0, 1'b0, '0},
    '{32'd3, 32'd1, 32'd16, 32'd15, 1'b0, '0},
    '{32'd3, 32'd1, 32'd16, 32'd16, 1'b0, '0},
    // full-period counter
    '{32'd1, 32'd1, 32'd64, 32'd0, 1'b1, '{32'd0, 32'd64, 1'b0}},
    '{32'd1, 32'd1, 32'd64, 32'd100, 1'b1, '{32'd1, 32'd64, 1'b0}},
    // doubling runs into the fixed point zero
    '{32'd2, 32'd0, 32'd16, 32'd1, 1'b1, '{32'd4, 32'd1, 1'b0}},
    '{32'd2, 32'd0, 32'd16, 32'h8000_0001, 1'b0, '0}
  };

  initial begin
    logic [31:0] a;
    logic [31:0] c;
    logic [31:0] m;
    logic [31:0] x0;
    int sent;
    int burst;
    int kind;
    seed_ch.valid <= 1'b0;
    seed_ch.start_value <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].mult !== mult_q || directed[i].inc !== inc_q ||
          directed[i].modv !== mod_q) begin
        drop_valid();
        set_generator(directed[i].mult, directed[i].inc, directed[i].modv);
      end
      send_seed(directed[i].start, directed[i].known, directed[i].want);
    end
    drop_valid();

    // random phases, each under fresh settings; waits for the block to drain
    sent = 0;
    while (sent < RandomSeeds) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        a = $urandom();
        c = $urandom();
        m = 32'd0;
      end else if (kind <= 2) begin
        // wide modulus with a step that settles at once
        m = $urandom() | 32'h8000_0000;
        a = $urandom_range(0, 1);
        c = (a == 0) ? $urandom() : 32'd0;
      end else begin
        // narrow modulus keeps cycles short, operands full width
        m = (kind == 9) ? $urandom_range(65, 200) : $urandom_range(1, 64);
        a = $urandom();
        c = $urandom();
      end
      set_generator(a, c, m);
      burst = $urandom_range(6, 14);
      repeat (burst) begin
        if (sent < RandomSeeds) begin
          quiet = (sent >= RandomSeeds - QuietTail);
          case ($urandom_range(0, 2))
            0: x0 = $urandom();
            1: x0 = (m == 0) ? $urandom() : $urandom_range(0, m - 1);
            default: x0 = 32'hFFFF_FFFF - $urandom_range(0, 3);
          endcase
          send_seed(x0, 1'b0, '0);
          sent++;
        end
      end
      drop_valid();
    end

    wait (pending_lengths.size() == 0);
    repeat (50) @(posedge clk);
    if (!failed) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
